// ----- design/nnc_pkg.sv -----
`default_nettype none

package nnc_pkg;

   localparam int MAX_POINTS_DEF = 256;
   localparam int DIMS_DEF       = 8;

   localparam int NCOORD      = 8;
   localparam int COORD_W     = 16;
   localparam int LABEL_W     = 4;
   localparam int CMD_W       = 2;
   localparam int STATUS_W    = 3;
   localparam int DIST_W      = 36;
   localparam int DIMS_CFG_W  = 4;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [DIMS_CFG_W-1:0] ACTIVE_DIMS_RESET = 4'd8;

   localparam logic [STATUS_W-1:0] ST_LOADED  = 3'd0;
   localparam logic [STATUS_W-1:0] ST_MATCH   = 3'd1;
   localparam logic [STATUS_W-1:0] ST_FULL    = 3'd2;
   localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd3;
   localparam logic [STATUS_W-1:0] ST_CLEARED = 3'd4;

   typedef enum logic [1:0] {
      OP_LOAD,
      OP_QUERY,
      OP_CLEAR
   } op_type;

   typedef logic signed [COORD_W-1:0] coord_type;

   typedef struct packed {
      op_type                     op;
      logic [LABEL_W-1:0]         label;
      coord_type [NCOORD-1:0]     coord;
   } item_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_ISSUE,
      BK_DRAIN
   } back_state_type;

endpackage

`default_nettype wire

// ----- design/nnc_if.sv -----
`default_nettype none

interface nnc_req_if import nnc_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CMD_W-1:0]     cmd;
   logic [LABEL_W-1:0]   label;
   logic [COORD_W-1:0]   coord0;
   logic [COORD_W-1:0]   coord1;
   logic [COORD_W-1:0]   coord2;
   logic [COORD_W-1:0]   coord3;
   logic [COORD_W-1:0]   coord4;
   logic [COORD_W-1:0]   coord5;
   logic [COORD_W-1:0]   coord6;
   logic [COORD_W-1:0]   coord7;

   modport source (
      output valid, cmd, label, coord0, coord1, coord2, coord3,
             coord4, coord5, coord6, coord7,
      input  ready
   );

   modport sink (
      input  valid, cmd, label, coord0, coord1, coord2, coord3,
             coord4, coord5, coord6, coord7,
      output ready
   );
endinterface

interface nnc_rsp_if import nnc_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [STATUS_W-1:0]   status;
   logic [LABEL_W-1:0]    match_label;
   logic [DIST_W-1:0]     match_distance;

   modport source (
      output valid, status, match_label, match_distance,
      input  ready
   );

   modport sink (
      input  valid, status, match_label, match_distance,
      output ready
   );
endinterface

`default_nettype wire

// ----- design/nnc_ram.sv -----
`default_nettype none

module nnc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- design/nnc_front.sv -----
`default_nettype none

module nnc_front import nnc_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   nnc_req_if.sink   req_ch,
   output logic      head_valid,
   output item_type  head,
   input  logic      pop
);

   localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

   item_type            slot_ff [QUEUE_DEPTH];
   item_type            item_in;
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [FILL_W-1:0]   fill_ff, fill_in;
   logic                push;

   // Command bit 1 means clear regardless of bit 0.
   always_comb begin
      if (req_ch.cmd[1]) begin
         item_in.op = OP_CLEAR;
      end else if (req_ch.cmd[0]) begin
         item_in.op = OP_QUERY;
      end else begin
         item_in.op = OP_LOAD;
      end
      item_in.label    = req_ch.label;
      item_in.coord[0] = req_ch.coord0;
      item_in.coord[1] = req_ch.coord1;
      item_in.coord[2] = req_ch.coord2;
      item_in.coord[3] = req_ch.coord3;
      item_in.coord[4] = req_ch.coord4;
      item_in.coord[5] = req_ch.coord5;
      item_in.coord[6] = req_ch.coord6;
      item_in.coord[7] = req_ch.coord7;
   end

   assign req_ch.ready = (fill_ff != FILL_W'(QUEUE_DEPTH));
   assign push         = req_ch.valid && req_ch.ready;
   assign head_valid   = (fill_ff != '0);
   assign head         = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      fill_in = fill_ff + FILL_W'(push) - FILL_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= item_in;
      end
   end

endmodule

`default_nettype wire

// ----- design/nnc_back.sv -----
`default_nettype none

module nnc_back import nnc_pkg::*; #(
   parameter int MAX_POINTS = MAX_POINTS_DEF,
   parameter int DIMS       = DIMS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [DIMS_CFG_W-1:0]  active_dims,
   input  logic                   head_valid,
   input  item_type               head,
   output logic                   pop,
   nnc_rsp_if.source              rsp_ch
);

   localparam int ADDR_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int CNT_W  = $clog2(MAX_POINTS + 1);
   localparam int RAM_W  = DIMS * COORD_W + LABEL_W;
   localparam int DIFF_W = COORD_W + 1;
   localparam int SQ_W   = 2 * COORD_W;
   localparam int PAIRS  = (DIMS + 1) / 2;
   localparam int PAIR_W = SQ_W + 1;

   back_state_type state_ff, state_in;

   logic [CNT_W-1:0]        count_ff, count_in;
   logic [CNT_W-1:0]        iss_ff;
   logic [DIMS_CFG_W-1:0]   dims_ff, dims_eff;
   coord_type               qc_ff [DIMS];

   // Control decisions of the current cycle.
   logic                    out_free;
   logic                    last_issue;
   logic                    start;
   logic                    rd_en;
   logic                    ram_we;
   logic [RAM_W-1:0]        wr_data;
   logic [RAM_W-1:0]        rd_data;
   logic                    out_load;
   logic [STATUS_W-1:0]     out_status;
   logic [LABEL_W-1:0]      out_label;
   logic [DIST_W-1:0]       out_dist;

   // Distance pipeline.
   logic                     v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic                     l1_ff, l2_ff, l3_ff, l4_ff, l5_ff;
   logic [LABEL_W-1:0]       lab2_ff, lab3_ff, lab4_ff, lab5_ff;
   logic signed [DIFF_W-1:0] diff_in [DIMS];
   logic signed [DIFF_W-1:0] diff_ff [DIMS];
   logic signed [2*DIFF_W-1:0] sq_full [DIMS];
   logic [SQ_W-1:0]          sq_ff [DIMS];
   logic [PAIR_W-1:0]        pair_in [PAIRS];
   logic [PAIR_W-1:0]        pair_ff [PAIRS];
   logic [DIST_W-1:0]        total_in, total_ff;

   logic [DIST_W-1:0]        best_ff;
   logic [LABEL_W-1:0]       best_lab_ff;
   logic                     best_valid_ff;
   logic                     better;

   logic                     rsp_valid_ff;
   logic [STATUS_W-1:0]      status_ff;
   logic [LABEL_W-1:0]       label_ff;
   logic [DIST_W-1:0]        dist_ff;

   assign out_free   = !rsp_valid_ff || rsp_ch.ready;
   assign last_issue = (iss_ff == count_ff - CNT_W'(1));

   always_comb begin
      if (active_dims == '0) begin
         dims_eff = DIMS_CFG_W'(1);
      end else if (active_dims > DIMS_CFG_W'(DIMS)) begin
         dims_eff = DIMS_CFG_W'(DIMS);
      end else begin
         dims_eff = active_dims;
      end
   end

   always_comb begin
      wr_data = '0;
      for (int k = 0; k < DIMS; k++) begin
         wr_data[k*COORD_W +: COORD_W] = head.coord[k];
      end
      wr_data[RAM_W-1 -: LABEL_W] = head.label;
   end

   nnc_ram #(
      .WIDTH (RAM_W),
      .DEPTH (MAX_POINTS)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (count_ff[ADDR_W-1:0]),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (iss_ff[ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (head_valid && out_free && head.op == OP_QUERY && count_ff != '0) begin
               state_in = BK_ISSUE;
            end
         end
         BK_ISSUE: begin
            if (last_issue) begin
               state_in = BK_DRAIN;
            end
         end
         BK_DRAIN: begin
            if (v5_ff && l5_ff) begin
               state_in = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   assign better = !best_valid_ff || (total_ff < best_ff);

   // Outputs of the controller.
   always_comb begin
      pop        = 1'b0;
      ram_we     = 1'b0;
      start      = 1'b0;
      rd_en      = 1'b0;
      out_load   = 1'b0;
      out_status = ST_LOADED;
      out_label  = '0;
      out_dist   = '0;
      count_in   = count_ff;
      case (state_ff)
         BK_IDLE: begin
            if (head_valid && out_free) begin
               pop      = 1'b1;
               out_load = 1'b1;
               case (head.op)
                  OP_LOAD: begin
                     if (count_ff == CNT_W'(MAX_POINTS)) begin
                        out_status = ST_FULL;
                     end else begin
                        ram_we     = 1'b1;
                        count_in   = count_ff + CNT_W'(1);
                        out_status = ST_LOADED;
                     end
                  end
                  OP_QUERY: begin
                     if (count_ff == '0) begin
                        out_status = ST_EMPTY;
                     end else begin
                        out_load = 1'b0;
                        start    = 1'b1;
                     end
                  end
                  OP_CLEAR: begin
                     count_in   = '0;
                     out_status = ST_CLEARED;
                  end
                  default: begin
                     count_in   = '0;
                     out_status = ST_CLEARED;
                  end
               endcase
            end
         end
         BK_ISSUE: begin
            rd_en = 1'b1;
         end
         BK_DRAIN: begin
         end
         default: begin
         end
      endcase
      // The last vector's compare closes the query.
      if (v5_ff && l5_ff) begin
         out_load   = 1'b1;
         out_status = ST_MATCH;
         out_label  = better ? lab5_ff : best_lab_ff;
         out_dist   = better ? total_ff : best_ff;
      end
   end

   // Datapath lanes: difference, square, pairwise sum, total.
   always_comb begin
      for (int k = 0; k < DIMS; k++) begin
         if (DIMS_CFG_W'(k) < dims_ff) begin
            diff_in[k] = $signed({rd_data[k*COORD_W + COORD_W - 1],
                                  rd_data[k*COORD_W +: COORD_W]})
                       - $signed({qc_ff[k][COORD_W-1], qc_ff[k]});
         end else begin
            diff_in[k] = '0;
         end
         sq_full[k] = diff_ff[k] * diff_ff[k];
      end
   end

   for (genvar p = 0; p < PAIRS; p++) begin : g_pair
      if (2 * p + 1 < DIMS) begin : g_two
         assign pair_in[p] = PAIR_W'(sq_ff[2*p]) + PAIR_W'(sq_ff[2*p+1]);
      end else begin : g_one
         assign pair_in[p] = PAIR_W'(sq_ff[2*p]);
      end
   end

   always_comb begin
      total_in = '0;
      for (int p = 0; p < PAIRS; p++) begin
         total_in = total_in + DIST_W'(pair_ff[p]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= BK_IDLE;
         count_ff      <= '0;
         iss_ff        <= '0;
         v1_ff         <= 1'b0;
         v2_ff         <= 1'b0;
         v3_ff         <= 1'b0;
         v4_ff         <= 1'b0;
         v5_ff         <= 1'b0;
         best_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         if (start) begin
            iss_ff <= '0;
         end else if (rd_en) begin
            iss_ff <= iss_ff + CNT_W'(1);
         end
         v1_ff <= rd_en;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         if (start) begin
            best_valid_ff <= 1'b0;
         end else if (v5_ff && better) begin
            best_valid_ff <= 1'b1;
         end
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         dims_ff <= dims_eff;
         for (int k = 0; k < DIMS; k++) begin
            qc_ff[k] <= head.coord[k];
         end
      end
      l1_ff   <= last_issue;
      l2_ff   <= l1_ff;
      l3_ff   <= l2_ff;
      l4_ff   <= l3_ff;
      l5_ff   <= l4_ff;
      lab2_ff <= rd_data[RAM_W-1 -: LABEL_W];
      lab3_ff <= lab2_ff;
      lab4_ff <= lab3_ff;
      lab5_ff <= lab4_ff;
      for (int k = 0; k < DIMS; k++) begin
         diff_ff[k] <= diff_in[k];
         sq_ff[k]   <= sq_full[k][SQ_W-1:0];
      end
      for (int p = 0; p < PAIRS; p++) begin
         pair_ff[p] <= pair_in[p];
      end
      total_ff <= total_in;
      if (v5_ff && better) begin
         best_ff     <= total_ff;
         best_lab_ff <= lab5_ff;
      end
      if (out_load) begin
         status_ff <= out_status;
         label_ff  <= out_label;
         dist_ff   <= out_dist;
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.status         = status_ff;
   assign rsp_ch.match_label    = label_ff;
   assign rsp_ch.match_distance = dist_ff;

endmodule

`default_nettype wire

// ----- design/nearest_neighbor_classifier_top.sv -----
`default_nettype none

// One-nearest-neighbor classifier over signed Q8.8 vectors with squared
// Euclidean distance. Load beats append a labelled vector to the store (or
// report full), clear beats empty it, and query beats return the label and
// exact distance of the first stored vector at the smallest distance (or
// report empty), using the first active_dims coordinates (0 acts as 1, values
// above DIMS act as DIMS). Requests pass through a two-beat queue, so the
// front keeps accepting while the back end works. Queries are paced by the
// single read port of the vector store, which feeds one vector a cycle into
// a five-stage distance pipeline. The store needs no clearing pass after
// reset.
// Write active_dims only while no beat is in flight.
module nearest_neighbor_classifier_top import nnc_pkg::*; #(
   parameter int MAX_POINTS = MAX_POINTS_DEF,
   parameter int DIMS       = DIMS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_enable,
   input  logic [DIMS_CFG_W-1:0]  csr_write_data,
   nnc_req_if.sink                req_ch,
   nnc_rsp_if.source              rsp_ch
);

   logic [DIMS_CFG_W-1:0] csr_active_dims_ff;
   logic                  head_valid;
   item_type              head;
   logic                  pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_active_dims_ff <= ACTIVE_DIMS_RESET;
      end else if (csr_write_enable) begin
         csr_active_dims_ff <= csr_write_data;
      end
   end

   nnc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop)
   );

   nnc_back #(
      .MAX_POINTS (MAX_POINTS),
      .DIMS       (DIMS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .active_dims (csr_active_dims_ff),
      .head_valid  (head_valid),
      .head        (head),
      .pop         (pop),
      .rsp_ch      (rsp_ch)
   );

endmodule

`default_nettype wire

// ----- tb/nearest_neighbor_classifier_top_tb.sv -----
`timescale 1ns / 100ps

module nearest_neighbor_classifier_top_tb;
   import nnc_pkg::*;

   localparam int CAPACITY = MAX_POINTS_DEF;
   localparam int PHASES = 9;
   localparam int PHASE_BEATS = 105;
   localparam int DRAIN_CYCLES = 20;
   localparam longint WATCHDOG_NS = 64'd20_000_000;

   // Command 3 has bit 1 set and clears the store like OP_CLEAR.
   localparam logic [CMD_W-1:0] CMD_CLEAR_ALIAS = 2'd3;
   localparam coord_type COORD_MIN = 16'h8000;
   localparam coord_type COORD_MAX = 16'h7FFF;

   typedef coord_type [NCOORD-1:0] vec_type;

   typedef struct packed {
      logic [CMD_W-1:0]   cmd;
      logic [LABEL_W-1:0] label;
      vec_type            coord;
   } req_beat_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [LABEL_W-1:0]  label;
      logic [DIST_W-1:0]   distance;
   } result_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_write_enable;
   logic [DIMS_CFG_W-1:0] csr_write_data;

   nnc_req_if req_bus ();
   nnc_rsp_if rsp_bus ();

   nearest_neighbor_classifier_top #(
      .MAX_POINTS (CAPACITY),
      .DIMS       (DIMS_DEF)
   ) i_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_ch           (req_bus),
      .rsp_ch           (rsp_bus)
   );

   // Predictor state: a copy of the vector store and the dimension register.
   vec_type              stored_vec [CAPACITY];
   logic [LABEL_W-1:0]   stored_label [CAPACITY];
   int unsigned          stored_count = 0;
   logic [DIMS_CFG_W-1:0] dims_cfg = ACTIVE_DIMS_RESET;

   req_beat_type pending_beats [$];
   result_type   expected_results [$];
   vec_type      gen_ref [$];
   req_beat_type beat_on_bus;
   result_type   want;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int beats_queued = 0;
   int beats_accepted = 0;
   int error_count = 0;
   int status_count [8] = '{default: 0};
   int dims_plan [PHASES];

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      #(WATCHDOG_NS);
      $display("DONE: errors detected");
      $finish;
   end

   function automatic result_type classify_beat(input req_beat_type b);
      result_type r;
      int unsigned dims;
      int unsigned i;
      int unsigned k;
      longint diff;
      longint sum;
      longint best;
      r = '0;
      if (b.cmd == OP_CLEAR || b.cmd == CMD_CLEAR_ALIAS) begin
         stored_count = 0;
         r.status = ST_CLEARED;
      end else if (b.cmd == OP_LOAD) begin
         if (stored_count >= CAPACITY) begin
            r.status = ST_FULL;
         end else begin
            stored_vec[stored_count] = b.coord;
            stored_label[stored_count] = b.label;
            stored_count++;
            r.status = ST_LOADED;
         end
      end else if (stored_count == 0) begin
         r.status = ST_EMPTY;
      end else begin
         dims = dims_cfg;
         if (dims == 0) dims = 1;
         if (dims > DIMS_DEF) dims = DIMS_DEF;
         best = -1;
         for (i = 0; i < stored_count; i++) begin
            sum = 0;
            for (k = 0; k < dims; k++) begin
               diff = longint'($signed(stored_vec[i][k])) - longint'($signed(b.coord[k]));
               sum += diff * diff;
            end
            // Strictly smaller only, so the earliest entry wins a tie.
            if (best < 0 || sum < best) begin
               best = sum;
               r.label = stored_label[i];
            end
         end
         r.status = ST_MATCH;
         r.distance = best[DIST_W-1:0];
      end
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            expected_results.insert(expected_results.size(), classify_beat(beat_on_bus));
            beats_accepted++;
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               beat_on_bus = pending_beats.pop_front();
               req_bus.cmd <= beat_on_bus.cmd;
               req_bus.label <= beat_on_bus.label;
               req_bus.coord0 <= beat_on_bus.coord[0];
               req_bus.coord1 <= beat_on_bus.coord[1];
               req_bus.coord2 <= beat_on_bus.coord[2];
               req_bus.coord3 <= beat_on_bus.coord[3];
               req_bus.coord4 <= beat_on_bus.coord[4];
               req_bus.coord5 <= beat_on_bus.coord[5];
               req_bus.coord6 <= beat_on_bus.coord[6];
               req_bus.coord7 <= beat_on_bus.coord[7];
               req_bus.valid <= 1'b1;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            status_count[rsp_bus.status]++;
            if (expected_results.size() == 0) begin
               $error("result beat with nothing expected: status %0d", rsp_bus.status);
               error_count++;
            end else begin
               want = expected_results.pop_front();
               if (rsp_bus.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_bus.status);
                  error_count++;
               end
               if (rsp_bus.match_label !== want.label) begin
                  $error("match_label: expected %0d, got %0d", want.label,
                         rsp_bus.match_label);
                  error_count++;
               end
               if (rsp_bus.match_distance !== want.distance) begin
                  $error("match_distance: expected %0d, got %0d", want.distance,
                         rsp_bus.match_distance);
                  error_count++;
               end
            end
         end
         rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   function automatic coord_type rand_coord();
      case ($urandom_range(7))
         0: return COORD_MIN;
         1: return COORD_MAX;
         2: return '0;
         3: return coord_type'(int'($urandom_range(1023)) - 512);
         default: return coord_type'($urandom());
      endcase
   endfunction

   function automatic vec_type rand_vec();
      vec_type v;
      int k;
      for (k = 0; k < NCOORD; k++) v[k] = rand_coord();
      return v;
   endfunction

   function automatic vec_type flat_vec(input coord_type c);
      vec_type v;
      int k;
      for (k = 0; k < NCOORD; k++) v[k] = c;
      return v;
   endfunction

   // A slightly moved copy of a vector loaded since the last clear, so that
   // the nearest entry is known to be close and ties come up now and then.
   function automatic vec_type near_vec();
      vec_type v;
      int k;
      if (gen_ref.size() == 0) return rand_vec();
      v = gen_ref[$urandom_range(gen_ref.size() - 1)];
      for (k = 0; k < NCOORD; k++) begin
         if ($urandom_range(2) == 0) v[k] = v[k] + coord_type'(int'($urandom_range(8)) - 4);
      end
      return v;
   endfunction

   function automatic vec_type load_vec();
      if (gen_ref.size() != 0 && $urandom_range(5) == 0)
         return gen_ref[$urandom_range(gen_ref.size() - 1)];
      return rand_vec();
   endfunction

   function automatic logic [CMD_W-1:0] clear_code();
      if ($urandom_range(1) == 0) return OP_CLEAR;
      return CMD_CLEAR_ALIAS;
   endfunction

   function automatic logic [LABEL_W-1:0] rand_label();
      return LABEL_W'($urandom_range(15));
   endfunction

   function automatic void queue_beat(input logic [CMD_W-1:0] cmd,
                                      input logic [LABEL_W-1:0] label, input vec_type v);
      req_beat_type b;
      b.cmd = cmd;
      b.label = label;
      b.coord = v;
      pending_beats.insert(pending_beats.size(), b);
      beats_queued++;
      if (cmd == OP_CLEAR || cmd == CMD_CLEAR_ALIAS) gen_ref.delete();
      else if (cmd == OP_LOAD && gen_ref.size() < CAPACITY) gen_ref.insert(gen_ref.size(), v);
   endfunction

   task automatic wait_drained();
      do @(negedge clock);
      while (pending_beats.size() != 0 || req_bus.valid || expected_results.size() != 0);
   endtask

   task automatic write_dims(input logic [DIMS_CFG_W-1:0] value);
      wait_drained();
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      dims_cfg = value;
      @(negedge clock);
   endtask

   task automatic gen_phase(input int budget, input bit fill);
      int start;
      int n;
      int r;
      start = beats_queued;
      if (fill) begin
         queue_beat(clear_code(), rand_label(), rand_vec());
         repeat (CAPACITY + 3) queue_beat(OP_LOAD, rand_label(), load_vec());
         repeat (6) queue_beat(OP_QUERY, rand_label(), near_vec());
      end
      while (beats_queued - start < budget) begin
         r = $urandom_range(99);
         if (r < 65) begin
            if ($urandom_range(3) != 0) queue_beat(clear_code(), rand_label(), rand_vec());
            n = ($urandom_range(4) == 0) ? $urandom_range(48, 13) : $urandom_range(12, 1);
            repeat (n) queue_beat(OP_LOAD, rand_label(), load_vec());
            repeat ($urandom_range(6, 1)) begin
               if ($urandom_range(4) == 0) queue_beat(OP_QUERY, rand_label(), rand_vec());
               else queue_beat(OP_QUERY, rand_label(), near_vec());
            end
         end else if (r < 80) begin
            repeat ($urandom_range(4, 1))
               queue_beat(CMD_W'($urandom_range(3)), rand_label(), rand_vec());
         end else if (r < 90) begin
            queue_beat(clear_code(), rand_label(), rand_vec());
            repeat ($urandom_range(3, 1)) queue_beat(OP_QUERY, rand_label(), rand_vec());
         end else begin
            // Keep adding to whatever the store already holds.
            repeat ($urandom_range(6, 1)) queue_beat(OP_LOAD, rand_label(), load_vec());
            queue_beat(OP_QUERY, rand_label(), near_vec());
         end
      end
   endtask

   initial begin
      vec_type alt_vec;
      int k;
      int p;
      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_write_data = '0;
      req_bus.valid = 1'b0;
      req_bus.cmd = '0;
      req_bus.label = '0;
      req_bus.coord0 = '0;
      req_bus.coord1 = '0;
      req_bus.coord2 = '0;
      req_bus.coord3 = '0;
      req_bus.coord4 = '0;
      req_bus.coord5 = '0;
      req_bus.coord6 = '0;
      req_bus.coord7 = '0;
      rsp_bus.ready = 1'b0;
      dims_plan = '{1, 0, 15, 8, 9, 4, 2, 7, 3};
      for (k = 0; k < NCOORD; k++) alt_vec[k] = k[0] ? COORD_MIN : COORD_MAX;

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_idle_pct = 18;
      recv_idle_pct = 84;
      queue_beat(OP_QUERY, 4'd7, rand_vec());
      queue_beat(OP_LOAD, 4'd15, flat_vec(COORD_MAX));
      queue_beat(OP_LOAD, 4'd0, flat_vec(COORD_MIN));
      queue_beat(OP_LOAD, 4'd5, flat_vec(COORD_MAX));
      // Hold the sender until the loads have all been answered.
      wait_drained();
      queue_beat(OP_QUERY, 4'd0, flat_vec(COORD_MIN));
      queue_beat(OP_QUERY, 4'd0, flat_vec(COORD_MAX));
      queue_beat(OP_QUERY, 4'd0, flat_vec('0));
      queue_beat(CMD_CLEAR_ALIAS, 4'd0, flat_vec('0));
      queue_beat(OP_QUERY, 4'd0, flat_vec(COORD_MIN));
      queue_beat(OP_LOAD, 4'd9, flat_vec(COORD_MAX));
      queue_beat(OP_QUERY, 4'd15, flat_vec(COORD_MIN));
      queue_beat(OP_LOAD, 4'd3, alt_vec);
      queue_beat(OP_QUERY, 4'd0, alt_vec);
      queue_beat(OP_QUERY, 4'd0, ~alt_vec);
      queue_beat(OP_CLEAR, 4'd0, flat_vec('0));
      queue_beat(OP_QUERY, 4'd0, rand_vec());
      queue_beat(OP_LOAD, 4'd10, flat_vec('0));
      queue_beat(OP_LOAD, 4'd11, flat_vec(coord_type'(1)));
      queue_beat(OP_LOAD, 4'd12, flat_vec(coord_type'(-1)));
      queue_beat(OP_QUERY, 4'd0, flat_vec(coord_type'(1)));
      queue_beat(OP_QUERY, 4'd0, rand_vec());

      for (p = 0; p < PHASES; p++) begin
         write_dims(DIMS_CFG_W'(dims_plan[p]));
         if (p < 3) begin
            send_idle_pct = 18;
            recv_idle_pct = 84;
         end else if (p < 6) begin
            send_idle_pct = 84;
            recv_idle_pct = 18;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         gen_phase(PHASE_BEATS, p == 1 || p == 7);
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Ran %0d request beats over %0d active_dims settings, stalling each side in turn.",
               beats_accepted, PHASES + 1);
      $display("Seen: %0d loaded, %0d dropped as full, %0d matches, %0d empty, %0d cleared.",
               status_count[ST_LOADED], status_count[ST_FULL], status_count[ST_MATCH],
               status_count[ST_EMPTY], status_count[ST_CLEARED]);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
